// ===== hw/rtl/bitmap_glyph_rasterizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// bitmap glyph rasterizer assertion macros
// concurrent checks that compile away under synthesis
// ----------------------------------------------------------------------------
`ifndef BITMAP_GLYPH_RASTERIZER_UNIT_MACROS_SVH
`define BITMAP_GLYPH_RASTERIZER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bgr same-cycle check failed");
// next-cycle implication
`define BGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bgr next-cycle check failed");
`else
`define BGR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BGR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bgr_pkg.sv =====
// ----------------------------------------------------------------------------
// bgr_pkg
// shared types and constants of the bitmap glyph rasterizer
// ----------------------------------------------------------------------------
package bgr_pkg;

  // input function codes
  localparam logic [1:0] FUNC_DEFINE = 2'd0;
  localparam logic [1:0] FUNC_ROW    = 2'd1;
  localparam logic [1:0] FUNC_PLACE  = 2'd2;
  localparam logic [1:0] FUNC_PRINT  = 2'd3;

  // first printable code (space)
  localparam int FIRST_CODE = 32;

  // configuration register indexes
  localparam int          CFG_ADDR_W    = 5;
  localparam logic [2:0]  REG_FONT_H    = 3'd0;
  localparam logic [2:0]  REG_FILL      = 3'd1;
  localparam logic [2:0]  REG_OUTLINE   = 3'd2;
  localparam logic [2:0]  REG_HIGHLIGHT = 3'd3;
  localparam logic [2:0]  REG_BACKGND   = 3'd4;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DEFINE,
    OP_ROW,
    OP_PLACE,
    OP_ADVANCE,
    OP_PRINT
  } cmd_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_DRAW
  } back_state_t;

  typedef struct packed {
    logic [7:0] fill;
    logic [7:0] outline;
    logic [7:0] highlight;
  } plane_row_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] slot;
    logic [3:0] width;
    logic [2:0] row;
    plane_row_t planes;
    logic [8:0] x;
    logic [7:0] y;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  font_height;
    logic [14:0] fill_color;
    logic [14:0] outline_color;
    logic [14:0] highlight_color;
    logic [14:0] background_color;
  } cfg_regs_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } front_status_t;

  typedef struct packed {
    back_state_t state;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [3:0]  width;
    logic [3:0]  height;
  } back_status_t;

endpackage

// ===== hw/rtl/bgr_if.sv =====
// ----------------------------------------------------------------------------
// bgr channel interfaces
// valid/ready channels for command items and pixel items
// ----------------------------------------------------------------------------
interface bgr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] glyph_slot;
  logic [3:0] glyph_width;
  logic [2:0] row_number;
  logic [7:0] fill_bits;
  logic [7:0] outline_bits;
  logic [7:0] highlight_bits;
  logic [8:0] place_x;
  logic [7:0] place_y;
  logic [7:0] letter;

  modport source (
    output valid, func, glyph_slot, glyph_width, row_number, fill_bits,
           outline_bits, highlight_bits, place_x, place_y, letter,
    input  ready
  );
  modport sink (
    input  valid, func, glyph_slot, glyph_width, row_number, fill_bits,
           outline_bits, highlight_bits, place_x, place_y, letter,
    output ready
  );
endinterface

interface bgr_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [14:0] pixel_color;
  logic        last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

// ===== hw/rtl/bgr_cfg.sv =====
// ----------------------------------------------------------------------------
// bgr_cfg
// apb register file: font height and the four plane colors
// ----------------------------------------------------------------------------
module bgr_cfg
  import bgr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_regs_t             cfg
);

  cfg_regs_t  regs_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.font_height      <= 4'd8;
      regs_r.fill_color       <= '0;
      regs_r.outline_color    <= '0;
      regs_r.highlight_color  <= '0;
      regs_r.background_color <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FONT_H:    regs_r.font_height      <= pwdata[3:0];
        REG_FILL:      regs_r.fill_color       <= pwdata[14:0];
        REG_OUTLINE:   regs_r.outline_color    <= pwdata[14:0];
        REG_HIGHLIGHT: regs_r.highlight_color  <= pwdata[14:0];
        REG_BACKGND:   regs_r.background_color <= pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FONT_H:    prdata = 32'(regs_r.font_height);
      REG_FILL:      prdata = 32'(regs_r.fill_color);
      REG_OUTLINE:   prdata = 32'(regs_r.outline_color);
      REG_HIGHLIGHT: prdata = 32'(regs_r.highlight_color);
      REG_BACKGND:   prdata = 32'(regs_r.background_color);
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/bgr_front.sv =====
// ----------------------------------------------------------------------------
// bgr_front
// accepts items, decodes them into commands and queues them for the back end
// ----------------------------------------------------------------------------
module bgr_front
  import bgr_pkg::*;
#(
  parameter int GLYPH_COUNT = 96,
  parameter int MAX_WIDTH   = 8,
  parameter int MAX_HEIGHT  = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  bgr_in_if.sink        in_ch,
  output cmd_t          cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop,
  output front_status_t fstat
);

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  cmd_t              new_cmd;
  logic              push;
  logic              pop;
  logic              slot_ok;
  logic              row_ok;
  logic              code_ok;

  assign in_ch.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count_r != '0);
  assign pop         = cmd_pop && cmd_valid;
  assign cmd         = q_r[rd_ptr_r];
  assign fstat.count = count_r;

  // classify the item
  always_comb begin
    slot_ok = ({1'b0, in_ch.glyph_slot} < 8'(GLYPH_COUNT));
    row_ok  = ({1'b0, in_ch.row_number} < 4'(MAX_HEIGHT));
    code_ok = ({1'b0, in_ch.letter} >= 9'(FIRST_CODE)) &&
              ({1'b0, in_ch.letter} < 9'(FIRST_CODE + GLYPH_COUNT));

    new_cmd.op     = OP_NOP;
    new_cmd.slot   = {1'b0, in_ch.glyph_slot};
    new_cmd.width  = (in_ch.glyph_width > 4'(MAX_WIDTH)) ? 4'(MAX_WIDTH) : in_ch.glyph_width;
    new_cmd.row    = in_ch.row_number;
    new_cmd.planes = '{fill: in_ch.fill_bits, outline: in_ch.outline_bits,
                       highlight: in_ch.highlight_bits};
    new_cmd.x      = in_ch.place_x;
    new_cmd.y      = in_ch.place_y;

    case (in_ch.func)
      FUNC_DEFINE: new_cmd.op = slot_ok ? OP_DEFINE : OP_NOP;
      FUNC_ROW:    new_cmd.op = (slot_ok && row_ok) ? OP_ROW : OP_NOP;
      FUNC_PLACE:  new_cmd.op = OP_PLACE;
      FUNC_PRINT: begin
        new_cmd.slot = in_ch.letter - 8'(FIRST_CODE);
        if (in_ch.letter == 8'd0) begin
          new_cmd.op = OP_NOP;
        end else if (code_ok) begin
          new_cmd.op = OP_PRINT;
        end else begin
          new_cmd.op = OP_ADVANCE;
        end
      end
      default: new_cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== hw/rtl/bgr_back.sv =====
// ----------------------------------------------------------------------------
// bgr_back
// glyph store and draw sequencer: runs queued commands, emits pixel items
// ----------------------------------------------------------------------------
module bgr_back
  import bgr_pkg::*;
#(
  parameter int GLYPH_COUNT = 96,
  parameter int MAX_HEIGHT  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_regs_t    cfg,
  input  cmd_t         cmd,
  input  logic         cmd_valid,
  output logic         cmd_pop,
  bgr_out_if.source    out_ch,
  output back_status_t bstat
);

  localparam int IW        = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int ROW_SLOTS = GLYPH_COUNT * MAX_HEIGHT;
  localparam int AW        = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;

  function automatic logic [AW-1:0] plane_addr(input logic [IW-1:0] idx,
                                               input logic [2:0] row);
    plane_addr = AW'(AW'(idx) * AW'(MAX_HEIGHT)) + AW'(row);
  endfunction

  // glyph store
  plane_row_t       plane_mem [ROW_SLOTS];
  logic [3:0]       width_mem [GLYPH_COUNT];
  plane_row_t       plane_rd_r;
  logic [3:0]       width_rd_r;
  logic [GLYPH_COUNT-1:0] valid_r;

  logic             pm_we;
  logic             pm_re;
  logic [AW-1:0]    pm_raddr;
  logic             wm_we;
  logic             wm_re;
  logic             valid_set;

  // sequencer state
  back_state_t      state_r, state_nxt;
  logic [8:0]       cur_x_r, cur_x_nxt;
  logic [7:0]       cur_y_r, cur_y_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [2:0]       row_r, row_nxt;
  logic [2:0]       col_r, col_nxt;
  logic [3:0]       w_r, w_nxt;
  logic [3:0]       h_r, h_nxt;
  plane_row_t       planes_r, planes_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [8:0]       out_x_r, out_x_nxt;
  logic [7:0]       out_y_r, out_y_nxt;
  logic [14:0]      out_color_r, out_color_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic             col_last;
  logic             row_last;
  logic [IW-1:0]    cmd_idx;

  assign out_free = !out_valid_r || out_ch.ready;
  assign col_last = ({1'b0, col_r} == (w_r - 4'd1));
  assign row_last = ({1'b0, row_r} == (h_r - 4'd1));
  assign cmd_idx  = cmd.slot[IW-1:0];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.last_pixel  = out_last_r;

  assign bstat.state  = state_r;
  assign bstat.row    = row_r;
  assign bstat.col    = col_r;
  assign bstat.width  = w_r;
  assign bstat.height = h_r;

  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    planes_nxt    = planes_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    cmd_pop       = 1'b0;
    pm_we         = 1'b0;
    pm_re         = 1'b0;
    pm_raddr      = plane_addr(idx_r, row_r);
    wm_we         = 1'b0;
    wm_re         = 1'b0;
    valid_set     = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_DEFINE: begin
              wm_we     = 1'b1;
              valid_set = 1'b1;
            end
            OP_ROW: pm_we = 1'b1;
            OP_PLACE: begin
              cur_x_nxt = cmd.x;
              cur_y_nxt = cmd.y;
            end
            OP_ADVANCE: cur_x_nxt = cur_x_r + 9'd1;
            OP_PRINT: begin
              if (valid_r[cmd_idx]) begin
                idx_nxt   = cmd_idx;
                row_nxt   = 3'd0;
                h_nxt     = (cfg.font_height > 4'(MAX_HEIGHT)) ? 4'(MAX_HEIGHT)
                                                               : cfg.font_height;
                wm_re     = 1'b1;
                pm_re     = 1'b1;
                pm_raddr  = plane_addr(cmd_idx, 3'd0);
                state_nxt = BK_FETCH;
              end else begin
                // glyph never defined: empty fallback
                cur_x_nxt = cur_x_r + 9'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      BK_FETCH: begin
        w_nxt      = width_rd_r;
        planes_nxt = plane_rd_r;
        col_nxt    = 3'd0;
        if (row_r == 3'd0 && (width_rd_r == 4'd0 || h_r == 4'd0)) begin
          // nothing to draw, only advance
          cur_x_nxt = cur_x_r + 9'(width_rd_r) + 9'd1;
          state_nxt = BK_IDLE;
        end else begin
          state_nxt = BK_DRAW;
        end
      end

      BK_DRAW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = cur_x_r + 9'(col_r);
          out_y_nxt     = cur_y_r + 8'(row_r);
          out_last_nxt  = row_last && col_last;
          if (planes_r.fill[col_r]) begin
            out_color_nxt = cfg.fill_color;
          end else if (planes_r.outline[col_r]) begin
            out_color_nxt = cfg.outline_color;
          end else if (planes_r.highlight[col_r]) begin
            out_color_nxt = cfg.highlight_color;
          end else begin
            out_color_nxt = cfg.background_color;
          end

          if (col_last) begin
            if (row_last) begin
              cur_x_nxt = cur_x_r + 9'(w_r) + 9'd1;
              state_nxt = BK_IDLE;
            end else begin
              row_nxt   = row_r + 3'd1;
              pm_re     = 1'b1;
              pm_raddr  = plane_addr(idx_r, row_r + 3'd1);
              state_nxt = BK_FETCH;
            end
          end else begin
            col_nxt = col_r + 3'd1;
          end
        end
      end

      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      w_r         <= '0;
      h_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      if (valid_set) begin
        valid_r[cmd_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    planes_r    <= planes_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  // plane memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (pm_we) begin
      plane_mem[plane_addr(cmd_idx, cmd.row)] <= cmd.planes;
    end
    if (pm_re) begin
      plane_rd_r <= plane_mem[pm_raddr];
    end
  end

  // width memory
  always_ff @(posedge clk) begin
    if (wm_we) begin
      width_mem[cmd_idx] <= cmd.width;
    end
    if (wm_re) begin
      width_rd_r <= width_mem[cmd_idx];
    end
  end

endmodule

// ===== hw/rtl/bitmap_glyph_rasterizer_unit.sv =====
// A printed w x h glyph occupies the draw sequencer: one pixel item per cycle from the
// output register while the sink is ready, plus one plane memory read per glyph row.
// The first pixel item passes queue, pop, row fetch and draw into the output register.
// Define, row write, place and unprintable letters each stay in the back end idle state.
// Reset is synchronous active low; glyph valid marks clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// bitmap_glyph_rasterizer_unit
// character generator: glyph store, command queue and pixel emitter
// ----------------------------------------------------------------------------
`include "bitmap_glyph_rasterizer_unit_macros.svh"

module bitmap_glyph_rasterizer_unit
  import bgr_pkg::*;
#(
  parameter int GLYPH_COUNT = 96,
  parameter int MAX_WIDTH   = 8,
  parameter int MAX_HEIGHT  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bgr_in_if.sink                in_ch,
  bgr_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_regs_t     cfg;
  cmd_t          cmd;
  logic          cmd_valid;
  logic          cmd_pop;
  front_status_t fstat;
  back_status_t  bstat;

  bgr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bgr_front #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .fstat     (fstat)
  );

  bgr_back #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch),
    .bstat     (bstat)
  );

  // reset leaves no pixel pending and the sequencer idle
  `BGR_ASSERT_NEXT(a_reset_quiet, clk, 1'b1, !rst_n, !out_ch.valid && bstat.state == BK_IDLE)
  // an accepted item always finds room in the queue
  `BGR_ASSERT_NOW(a_queue_room, clk, rst_n, in_ch.valid && in_ch.ready, fstat.count < QCNT_W'(QUEUE_DEPTH))
  // drawing stays inside the glyph box
  `BGR_ASSERT_NOW(a_draw_bounds, clk, rst_n, bstat.state == BK_DRAW, ({1'b0, bstat.col} < bstat.width) && ({1'b0, bstat.row} < bstat.height))

endmodule
